FILE: rtl/ctp_pkg.sv
`timescale 1ns / 1ps

package ctp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] HEX_MAX   = 4'd8;
  localparam logic [3:0] HEX_SHORT = 4'd3;
  localparam logic [3:0] HEX_RGB   = 4'd6;
  localparam logic [2:0] NUM_MAX   = 3'd4;
  localparam logic [2:0] NUM_MIN   = 3'd3;
  localparam logic [7:0] BYTE_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_HEX  = 2'd1,
    PH_DEC  = 2'd2
  } phase_t;

  // character item handed from the input register to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } chr_t;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } res_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

FILE: rtl/ctp_in_stage.sv
`timescale 1ns / 1ps

module ctp_in_stage
  import ctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       slot_free,
  output chr_t       chr
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] ch_r;
  logic       take;

  // a terminator only moves on when the result register can take its item
  assign take      = valid_r && ((ch_r != CH_NUL) || slot_free);
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

  assign chr.valid = take;
  assign chr.ch    = ch_r;

endmodule

FILE: rtl/ctp_parse.sv
`timescale 1ns / 1ps

module ctp_parse
  import ctp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  chr_t chr,
  output res_t res
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] hex_cnt_r, hex_cnt_nxt;
  logic       hex_stop_r, hex_stop_nxt;
  logic [3:0] hex_dig_r [8];
  logic       hex_we;
  logic [2:0] num_cnt_r, num_cnt_nxt;
  logic       in_num_r, in_num_nxt;
  logic [7:0] num_val_r, num_val_nxt;
  logic [7:0] comp_r [4];
  logic [7:0] comp_nxt [4];

  logic       term, ws, hash, digit;
  logic [4:0] nib;
  logic       dec_go;
  logic [11:0] acc;
  logic [7:0] acc_sat;

  logic       fin_take;
  logic [2:0] fin_cnt;
  logic [7:0] fin_comp [4];

  assign term  = (chr.ch == CH_NUL);
  assign ws    = (chr.ch == CH_SPACE) || (chr.ch == CH_TAB) ||
                 (chr.ch == CH_LF) || (chr.ch == CH_CR);
  assign hash  = (chr.ch == CH_HASH);
  assign digit = (chr.ch >= CH_ZERO) && (chr.ch <= CH_NINE);
  assign nib   = hex_nibble(chr.ch);

  // first non-blank character that is not '#' is already a decimal character
  assign dec_go = chr.valid && !term && (phase_r != PH_HEX) &&
                  !((phase_r == PH_SKIP) && (ws || hash));

  // value * 10 + digit, saturating
  assign acc = ({4'd0, num_val_r} << 3) + ({4'd0, num_val_r} << 1) +
               {4'd0, chr.ch - CH_ZERO};
  assign acc_sat = (acc > 12'd255) ? BYTE_MAX : acc[7:0];

  always_comb begin
    phase_nxt = phase_r;
    if (chr.valid) begin
      if (term) begin
        phase_nxt = PH_SKIP;
      end else begin
        unique case (phase_r)
          PH_SKIP: if (!ws) phase_nxt = hash ? PH_HEX : PH_DEC;
          PH_HEX:  phase_nxt = PH_HEX;
          PH_DEC:  phase_nxt = PH_DEC;
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_comb begin
    hex_cnt_nxt  = hex_cnt_r;
    hex_stop_nxt = hex_stop_r;
    hex_we       = 1'b0;
    num_cnt_nxt  = num_cnt_r;
    in_num_nxt   = in_num_r;
    num_val_nxt  = num_val_r;
    for (int i = 0; i < 4; i++) comp_nxt[i] = comp_r[i];

    if (chr.valid && term) begin
      hex_cnt_nxt  = 4'd0;
      hex_stop_nxt = 1'b0;
      num_cnt_nxt  = 3'd0;
      in_num_nxt   = 1'b0;
      num_val_nxt  = 8'd0;
      comp_nxt[0]  = 8'd0;
      comp_nxt[1]  = 8'd0;
      comp_nxt[2]  = 8'd0;
      comp_nxt[3]  = BYTE_MAX;
    end else if (chr.valid && (phase_r == PH_HEX)) begin
      if (!hex_stop_r && (hex_cnt_r < HEX_MAX)) begin
        if (nib[4]) begin
          hex_we      = 1'b1;
          hex_cnt_nxt = hex_cnt_r + 4'd1;
        end else begin
          hex_stop_nxt = 1'b1;
        end
      end
    end else if (dec_go && (num_cnt_r < NUM_MAX)) begin
      if (digit) begin
        num_val_nxt = in_num_r ? acc_sat : (chr.ch - CH_ZERO);
        in_num_nxt  = 1'b1;
      end else if (in_num_r) begin
        comp_nxt[num_cnt_r[1:0]] = num_val_r;
        num_cnt_nxt = num_cnt_r + 3'd1;
        in_num_nxt  = 1'b0;
        num_val_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SKIP;
      hex_cnt_r  <= 4'd0;
      hex_stop_r <= 1'b0;
      num_cnt_r  <= 3'd0;
      in_num_r   <= 1'b0;
      num_val_r  <= 8'd0;
      comp_r[0]  <= 8'd0;
      comp_r[1]  <= 8'd0;
      comp_r[2]  <= 8'd0;
      comp_r[3]  <= BYTE_MAX;
    end else begin
      phase_r    <= phase_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      hex_stop_r <= hex_stop_nxt;
      num_cnt_r  <= num_cnt_nxt;
      in_num_r   <= in_num_nxt;
      num_val_r  <= num_val_nxt;
      for (int i = 0; i < 4; i++) comp_r[i] <= comp_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (hex_we) begin
      hex_dig_r[hex_cnt_r[2:0]] <= nib[3:0];
    end
  end

  // a number still open at the terminator counts
  assign fin_take = in_num_r && (num_cnt_r < NUM_MAX);
  assign fin_cnt  = num_cnt_r + {2'd0, fin_take};
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fin_comp[i] = (fin_take && (num_cnt_r[1:0] == 2'(i))) ? num_val_r : comp_r[i];
    end
  end

  always_comb begin
    res.valid = chr.valid && term;
    res.ok    = 1'b0;
    res.red   = 8'd0;
    res.green = 8'd0;
    res.blue  = 8'd0;
    res.alpha = 8'd0;
    unique case (phase_r)
      PH_SKIP: ;
      PH_HEX: begin
        if (hex_cnt_r == HEX_SHORT) begin
          res.ok    = 1'b1;
          res.red   = {hex_dig_r[0], hex_dig_r[0]};
          res.green = {hex_dig_r[1], hex_dig_r[1]};
          res.blue  = {hex_dig_r[2], hex_dig_r[2]};
          res.alpha = BYTE_MAX;
        end else if ((hex_cnt_r == HEX_RGB) || (hex_cnt_r == HEX_MAX)) begin
          res.ok    = 1'b1;
          res.red   = {hex_dig_r[0], hex_dig_r[1]};
          res.green = {hex_dig_r[2], hex_dig_r[3]};
          res.blue  = {hex_dig_r[4], hex_dig_r[5]};
          res.alpha = (hex_cnt_r == HEX_MAX) ? {hex_dig_r[6], hex_dig_r[7]} : BYTE_MAX;
        end
      end
      default: begin
        if (fin_cnt >= NUM_MIN) begin
          res.ok    = 1'b1;
          res.red   = fin_comp[0];
          res.green = fin_comp[1];
          res.blue  = fin_comp[2];
          res.alpha = fin_comp[3];
        end
      end
    endcase
  end

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (chr.valid && term) |=> (phase_r == PH_SKIP) && (hex_cnt_r == 4'd0) &&
                           (num_cnt_r == 3'd0) && !in_num_r)
    else $error("state not cleared after terminator");

  a_hex_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hex_cnt_r <= HEX_MAX)
    else $error("hex digit count overflow");

  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    num_cnt_r <= NUM_MAX)
    else $error("number count overflow");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.ok) |-> ({res.red, res.green, res.blue, res.alpha} == 32'd0))
    else $error("refused item carries non-zero colour");

  a_hex_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEX) |-> (hex_cnt_r == 4'd0) && !hex_stop_r)
    else $error("hex state outside hex phase");

endmodule

FILE: rtl/ctp_out_stage.sv
`timescale 1ns / 1ps

module ctp_out_stage
  import ctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res,
  output logic       slot_free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_ok,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  logic       valid_r;
  logic       valid_nxt;
  logic       ok_r;
  logic [7:0] red_r, green_r, blue_r, alpha_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = res.valid || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      ok_r    <= res.ok;
      red_r   <= res.red;
      green_r <= res.green;
      blue_r  <= res.blue;
      alpha_r <= res.alpha;
    end
  end

  assign out_valid = valid_r;
  assign out_ok    = ok_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;

  // the input side must never push a result into an occupied, stalled slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> slot_free)
    else $error("result item lost in output register");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> valid_r)
    else $error("loaded item not presented");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> valid_r && $stable(ok_r) && $stable(red_r))
    else $error("stalled item changed");

endmodule

FILE: rtl/colour_text_parser.sv
`timescale 1ns / 1ps
// channel | signals                                   | accepted when
// --------+-------------------------------------------+-------------------------
// input   | in_valid, in_ready, in_ch                 | in_valid && in_ready
// result  | out_valid, out_ready, out_ok, out_red,    | out_valid && out_ready
//         | out_green, out_blue, out_alpha            |
//
// One character item per cycle while no terminator is held: an input register,
// then the parse step into the result register, which presents the item's result.
// Only the terminator (code 0) gives a result item; other characters never stall.
// A terminator waits in the input register while the result register is full
// and not taken; the input register then blocks further items.
// Synchronous active-low reset; parser state returns to its idle values.

module colour_text_parser
  import ctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_ok,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  chr_t chr;
  res_t res;
  logic slot_free;

  ctp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .slot_free(slot_free),
    .chr      (chr)
  );

  ctp_parse u_parse (
    .clk  (clk),
    .rst_n(rst_n),
    .chr  (chr),
    .res  (res)
  );

  ctp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .slot_free(slot_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ok   (out_ok),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .out_alpha(out_alpha)
  );

endmodule
